@@ src/assert_macros.svh @@
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed on the delay line ports");

// Expression that must never be true outside reset.
`define ASSERT_NEVER(label, expr) \
	`ASSERT_CLK(label, !(expr))

`endif

@@ src/mdlcf_pkg.sv @@
// Shared constants and a helper function of the modulated delay line.
package mdlcf_pkg;

	// Sample store geometry.
	localparam int STORE_DEPTH = 4096;
	localparam int EXTRA_TAPS = 3;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int LEN_CAP = STORE_DEPTH - EXTRA_TAPS;

	// Field widths.
	localparam int SAMPLE_W = 24;
	localparam int LEN_W = 12;
	localparam int MOD_W = 17;
	localparam int GAIN_W = 16;
	localparam int POS_W = 32;
	localparam int FRAC_W = 16;
	localparam int TGT_W = MOD_W + LEN_W;

	// Serial multiplier operand widths and step count.
	localparam int MCAND_W = 34;
	localparam int MPLIER_W = 18;
	localparam int PROD_W = MCAND_W + MPLIER_W;
	localparam int MUL_STEPS = MPLIER_W;

	// Serial divider step count.
	localparam int DIV_STEPS = 32;

	// Configuration register indexes.
	localparam logic REG_DELAY_LENGTH = 1'b0;
	localparam logic REG_MODE = 1'b1;

	// Item actions and delay modes.
	localparam logic ACT_PROCESS = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;
	localparam logic MODE_ANALOG = 1'b0;
	localparam logic MODE_DIGITAL = 1'b1;

	// Saturate a wide signed value to the 24-bit sample range.
	function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [35:0] v);
		logic signed [35:0] hi;
		logic signed [35:0] lo;
		hi = 36'sd8388607;
		lo = -36'sd8388608;
		if (v > hi) begin
			return 24'sh7FFFFF;
		end else if (v < lo) begin
			return 24'sh800000;
		end
		return v[SAMPLE_W-1:0];
	endfunction

endpackage

@@ src/mdlcf_sermul.sv @@
// Shift-and-add serial multiplier, one multiplier bit per cycle, signed operands.
module mdlcf_sermul (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [mdlcf_pkg::MCAND_W-1:0]  a,
	input  logic signed [mdlcf_pkg::MPLIER_W-1:0] b,
	output logic                                 done,
	output logic signed [mdlcf_pkg::PROD_W-1:0]   prod
);
	import mdlcf_pkg::*;

	logic                       busy_q;
	logic                       done_q;
	logic [$clog2(MUL_STEPS)-1:0] cnt_q;
	logic signed [PROD_W-1:0]   mcand_q;
	logic [MPLIER_W-1:0]        mplier_q;
	logic signed [PROD_W-1:0]   acc_q;
	logic                       last_step;

	// The top multiplier bit carries negative weight.
	assign last_step = (cnt_q == ($clog2(MUL_STEPS))'(MUL_STEPS - 1));

	// Control: count the steps and flag the end.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: one partial product is added or subtracted per cycle.
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= PROD_W'(a);
			mplier_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (mplier_q[0]) begin
				acc_q <= last_step ? (acc_q - mcand_q) : (acc_q + mcand_q);
			end
			mcand_q <= mcand_q <<< 1;
			mplier_q <= mplier_q >> 1;
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

@@ src/mdlcf_serdiv.sv @@
// Restoring serial divider, one quotient bit per cycle, for the glide step.
module mdlcf_serdiv (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [mdlcf_pkg::POS_W-1:0]       dividend,
	input  logic [mdlcf_pkg::TGT_W-1:0]       divisor,
	output logic                              done,
	output logic [mdlcf_pkg::POS_W-1:0]       quotient
);
	import mdlcf_pkg::*;

	logic                           busy_q;
	logic                           done_q;
	logic [$clog2(DIV_STEPS)-1:0]   cnt_q;
	logic [TGT_W:0]                 rem_q;
	logic [POS_W-1:0]               sh_q;
	logic [POS_W-1:0]               quo_q;
	logic [TGT_W-1:0]               dvs_q;
	logic [TGT_W+1:0]               trial;
	logic [TGT_W+1:0]               shifted;

	// Trial subtraction of the divisor from the shifted remainder.
	assign shifted = {rem_q, sh_q[POS_W-1]};
	assign trial = shifted - {2'b00, dvs_q};

	// Control: count the quotient bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(DIV_STEPS))'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath. The dividend is the position shifted up by 16 bits; its upper
	// half is below the divisor, so it seeds the remainder directly.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (TGT_W+1)'(dividend[POS_W-1:FRAC_W]);
			sh_q <= {dividend[FRAC_W-1:0], {(POS_W-FRAC_W){1'b0}}};
			quo_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			sh_q <= sh_q << 1;
			if (!trial[TGT_W+1]) begin
				rem_q <= trial[TGT_W:0];
				quo_q <= {quo_q[POS_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[TGT_W:0];
				quo_q <= {quo_q[POS_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

@@ src/modulated_delay_line_cubic_feedback_core.sv @@
// Top level: modulated delay line with feedback and cubic Hermite read.
// A sample item runs the target and feedback products on the shared serial multiplier, a divider
// pass in analog mode only, the tap reads, then the interpolation products; that is five
// multiplier passes for a cubic read and three for a linear read.
// A clear item or a delay_length write runs a clearing pass over the whole sample store; a clear
// item's result follows that pass. One item at a time; reset also runs the clearing pass.
module modulated_delay_line_cubic_feedback_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic                                   cfg_index,
	input  logic [mdlcf_pkg::LEN_W-1:0]            cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   action,
	input  logic signed [mdlcf_pkg::SAMPLE_W-1:0]  audio_in,
	input  logic [mdlcf_pkg::MOD_W-1:0]            modulation,
	input  logic signed [mdlcf_pkg::GAIN_W-1:0]    feedback_gain,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [mdlcf_pkg::SAMPLE_W-1:0]  audio_out
);
	import mdlcf_pkg::*;

	typedef enum logic [10:0] {
		ST_CLEAR = 11'b00000000001,
		ST_IDLE  = 11'b00000000010,
		ST_TGT   = 11'b00000000100,
		ST_FB    = 11'b00000001000,
		ST_DIV   = 11'b00000010000,
		ST_WRITE = 11'b00000100000,
		ST_READ  = 11'b00001000000,
		ST_MA    = 11'b00010000000,
		ST_MB    = 11'b00100000000,
		ST_MC    = 11'b01000000000,
		ST_DONE  = 11'b10000000000
	} state_t;

	state_t                       state_q;
	logic [LEN_W-1:0]             delay_length_q;
	logic                         mode_q;
	logic [ADDR_W-1:0]            clr_cnt_q;
	logic                         pend_zero_q;
	logic [LEN_W-1:0]             wi_q;
	logic [POS_W-1:0]             rp_q;
	logic signed [SAMPLE_W-1:0]   lo_q;
	logic signed [SAMPLE_W-1:0]   x_q;
	logic signed [GAIN_W-1:0]     g_q;
	logic [TGT_W-1:0]             target_q;
	logic signed [SAMPLE_W-1:0]   wdata_q;
	logic [LEN_W-1:0]             ip_q;
	logic [FRAC_W-1:0]            frac_q;
	logic [2:0]                   rd_cnt_q;
	logic signed [SAMPLE_W-1:0]   y_q [4];
	logic signed [SAMPLE_W-1:0]   res_q;
	logic                         out_valid_q;
	logic signed [SAMPLE_W-1:0]   audio_out_q;

	// Sample store.
	logic signed [SAMPLE_W-1:0]   mem [STORE_DEPTH];
	logic signed [SAMPLE_W-1:0]   rdata_q;
	logic                         mem_we;
	logic [ADDR_W-1:0]            mem_waddr;
	logic signed [SAMPLE_W-1:0]   mem_wdata;
	logic [ADDR_W-1:0]            mem_raddr;

	// Arithmetic units: the shared serial multiplier and the divider.
	logic                         mul_start_q;
	logic signed [MCAND_W-1:0]    mul_a_q;
	logic signed [MPLIER_W-1:0]   mul_b_q;
	logic                         mul_done;
	logic signed [PROD_W-1:0]     mul_prod;
	logic                         div_start_q;
	logic                         div_done;
	logic [POS_W-1:0]             div_quo;

	logic [LEN_W-1:0]             len;
	logic [LEN_W:0]               p;
	logic                         cfg_fire;
	logic                         in_fire;
	logic [TGT_W-1:0]             divisor;
	logic [POS_W:0]               glide;
	logic [FRAC_W-1:0]            ip_raw;
	logic                         ip_over;
	logic [LEN_W:0]               tap_k;
	logic [LEN_W+1:0]             tap_sum;
	logic [LEN_W+1:0]             tap_idx;
	logic [LEN_W:0]               wi_next;
	logic signed [MCAND_W-1:0]    y0e;
	logic signed [MCAND_W-1:0]    y1e;
	logic signed [MCAND_W-1:0]    y2e;
	logic signed [MCAND_W-1:0]    y3e;
	logic signed [MCAND_W-1:0]    coef_a;
	logic signed [MCAND_W-1:0]    coef_b;
	logic signed [MCAND_W-1:0]    coef_c;
	logic signed [MCAND_W-1:0]    lin_d;
	logic signed [PROD_W-1:0]     fb_full;
	logic signed [SAMPLE_W-1:0]   fb_sum;
	logic signed [SAMPLE_W-1:0]   hermite_r;
	logic signed [SAMPLE_W-1:0]   linear_r;

	// Effective length and ring size.
	assign len = (delay_length_q > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : delay_length_q;
	assign p = (LEN_W+1)'(len) + (LEN_W+1)'(EXTRA_TAPS);

	assign cfg_ready = 1'b1;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;

	// Glide target held at one sample or more, and the next analog position.
	assign divisor = (target_q < TGT_W'(32'h10000)) ? TGT_W'(32'h10000) : target_q;
	assign glide = {1'b0, rp_q} + (POS_W+1)'(32'h10000) - {1'b0, div_quo};

	// Integer position limit; digital mode already clamps when the integer part reaches the length.
	assign ip_raw = rp_q[POS_W-1:FRAC_W];
	assign ip_over = (mode_q == MODE_DIGITAL) ? (ip_raw >= FRAC_W'(len))
		: (ip_raw > FRAC_W'(len));

	// Ring address of the tap at delay ip-1+j behind the newest sample.
	always_comb begin
		if (ip_q == '0 && rd_cnt_q[1:0] == 2'd0) begin
			tap_k = '0;
		end else begin
			tap_k = (LEN_W+1)'(ip_q) + (LEN_W+1)'(rd_cnt_q[1:0]) - (LEN_W+1)'(1);
		end
		tap_sum = (LEN_W+2)'(wi_q) + (LEN_W+2)'(p) - (LEN_W+2)'(tap_k);
		tap_idx = (tap_sum >= (LEN_W+2)'(p)) ? (tap_sum - (LEN_W+2)'(p)) : tap_sum;
	end

	assign wi_next = (LEN_W+1)'(wi_q) + (LEN_W+1)'(1);

	// Interpolation terms; y3 comes straight from the store on the last read.
	assign y0e = MCAND_W'(y_q[0]);
	assign y1e = MCAND_W'(y_q[1]);
	assign y2e = MCAND_W'(y_q[2]);
	assign y3e = (state_q == ST_READ) ? MCAND_W'(rdata_q) : MCAND_W'(y_q[3]);
	assign coef_a = ((y1e - y2e) <<< 1) + (y1e - y2e) + y3e - y0e;
	assign coef_b = (y0e <<< 1) - (y1e <<< 2) - y1e + (y2e <<< 2) - y3e
		+ MCAND_W'(mul_prod >>> 16);
	assign coef_c = y2e - y0e + MCAND_W'(mul_prod >>> 16);
	assign lin_d = y2e - y1e;
	assign hermite_r = sat24(36'(y_q[1]) + 36'(mul_prod >>> 17));
	assign linear_r = sat24(36'(y_q[1]) + 36'(mul_prod >>> 16));

	// Feedback sum written into the ring.
	assign fb_full = (mul_prod + PROD_W'(8192)) >>> 14;
	assign fb_sum = sat24(36'(x_q) + 36'(fb_full));

	// Store write port: clearing pass or the new sample.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = wi_q;
		mem_wdata = wdata_q;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = '0;
		end else if (state_q == ST_WRITE) begin
			mem_we = 1'b1;
		end
		mem_raddr = tap_idx[ADDR_W-1:0];
	end

	// Sample store, one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_length_q <= '0;
			mode_q <= MODE_ANALOG;
		end else if (cfg_fire) begin
			if (cfg_index == REG_DELAY_LENGTH) begin
				delay_length_q <= cfg_data;
			end else begin
				mode_q <= cfg_data[0];
			end
		end
	end

	// Sequencer and control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_cnt_q <= '0;
			pend_zero_q <= 1'b0;
			wi_q <= '0;
			rp_q <= '0;
			lo_q <= '0;
			rd_cnt_q <= '0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_fire && cfg_index == REG_DELAY_LENGTH) begin
				// A new length empties the ring and restarts writing; no result follows.
				state_q <= ST_CLEAR;
				clr_cnt_q <= '0;
				pend_zero_q <= 1'b0;
				wi_q <= '0;
			end else begin
				case (state_q)
					ST_CLEAR: begin
						clr_cnt_q <= clr_cnt_q + 1'b1;
						if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
							state_q <= pend_zero_q ? ST_DONE : ST_IDLE;
						end
					end
					ST_IDLE: begin
						if (in_fire) begin
							if ((LEN_W+1)'(wi_q) >= p) begin
								wi_q <= '0;
							end
							if (action == ACT_CLEAR) begin
								pend_zero_q <= 1'b1;
								clr_cnt_q <= '0;
								state_q <= ST_CLEAR;
							end else begin
								pend_zero_q <= 1'b0;
								mul_start_q <= 1'b1;
								state_q <= ST_TGT;
							end
						end
					end
					ST_TGT: begin
						if (mul_done) begin
							mul_start_q <= 1'b1;
							state_q <= ST_FB;
						end
					end
					ST_FB: begin
						if (mul_done) begin
							if (mode_q == MODE_DIGITAL) begin
								rp_q <= POS_W'(target_q);
								state_q <= ST_WRITE;
							end else begin
								div_start_q <= 1'b1;
								state_q <= ST_DIV;
							end
						end
					end
					ST_DIV: begin
						if (div_done) begin
							rp_q <= glide[POS_W] ? '1 : glide[POS_W-1:0];
							state_q <= ST_WRITE;
						end
					end
					ST_WRITE: begin
						rd_cnt_q <= '0;
						state_q <= ST_READ;
					end
					ST_READ: begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
						if (rd_cnt_q == 3'd4) begin
							mul_start_q <= 1'b1;
							state_q <= ST_MA;
						end
					end
					ST_MA: begin
						if (mul_done) begin
							if (ip_q == '0) begin
								lo_q <= linear_r;
								wi_q <= (wi_next >= p) ? '0 : wi_next[LEN_W-1:0];
								state_q <= ST_DONE;
							end else begin
								mul_start_q <= 1'b1;
								state_q <= ST_MB;
							end
						end
					end
					ST_MB: begin
						if (mul_done) begin
							mul_start_q <= 1'b1;
							state_q <= ST_MC;
						end
					end
					ST_MC: begin
						if (mul_done) begin
							lo_q <= hermite_r;
							wi_q <= (wi_next >= p) ? '0 : wi_next[LEN_W-1:0];
							state_q <= ST_DONE;
						end
					end
					ST_DONE: begin
						if (!out_valid_q || out_ready) begin
							out_valid_q <= 1'b1;
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	// Item fields, operands and intermediate results.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= audio_in;
			g_q <= feedback_gain;
			// Glide target is length times modulation.
			mul_a_q <= MCAND_W'(len);
			mul_b_q <= MPLIER_W'(modulation);
		end
		case (state_q)
			ST_TGT: begin
				if (mul_done) begin
					target_q <= mul_prod[TGT_W-1:0];
					mul_a_q <= MCAND_W'(lo_q);
					mul_b_q <= MPLIER_W'(g_q);
				end
			end
			ST_FB: begin
				if (mul_done) begin
					wdata_q <= fb_sum;
				end
			end
			ST_WRITE: begin
				ip_q <= ip_over ? len : ip_raw[LEN_W-1:0];
				frac_q <= ip_over ? '0 : rp_q[FRAC_W-1:0];
			end
			ST_READ: begin
				if (rd_cnt_q != 3'd0) begin
					y_q[rd_cnt_q[1:0] - 2'd1] <= rdata_q;
				end
				if (rd_cnt_q == 3'd4) begin
					mul_a_q <= (ip_q == '0) ? lin_d : coef_a;
					mul_b_q <= MPLIER_W'(frac_q);
				end
			end
			ST_MA: begin
				if (mul_done) begin
					res_q <= linear_r;
					mul_a_q <= coef_b;
				end
			end
			ST_MB: begin
				if (mul_done) begin
					mul_a_q <= coef_c;
				end
			end
			ST_MC: begin
				if (mul_done) begin
					res_q <= hermite_r;
				end
			end
			ST_CLEAR: begin
				res_q <= '0;
			end
			default: begin
			end
		endcase
		if (state_q == ST_DONE && (!out_valid_q || out_ready)) begin
			audio_out_q <= res_q;
		end
	end

	mdlcf_sermul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start_q),
		.a      (mul_a_q),
		.b      (mul_b_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	mdlcf_serdiv u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (rp_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_valid = out_valid_q;
	assign audio_out = audio_out_q;

endmodule

@@ src/mdlcf_chk.sv @@
// Port-level checker for the delay line, attached to the top level by bind.
`include "assert_macros.svh"

module mdlcf_chk (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   cfg_valid,
	input logic                                   cfg_ready,
	input logic                                   cfg_index,
	input logic [mdlcf_pkg::LEN_W-1:0]            cfg_data,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic                                   action,
	input logic signed [mdlcf_pkg::SAMPLE_W-1:0]  audio_in,
	input logic [mdlcf_pkg::MOD_W-1:0]            modulation,
	input logic signed [mdlcf_pkg::GAIN_W-1:0]    feedback_gain,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [mdlcf_pkg::SAMPLE_W-1:0]  audio_out
);
	import mdlcf_pkg::*;

	// A waiting result keeps its value.
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(audio_out))

	// Only one item is in work at a time.
	`ASSERT_CLK(a_one_item, in_valid && in_ready |=> !in_ready)

	// A result never appears in the cycle right after its item was taken.
	`ASSERT_CLK(a_min_latency, $rose(out_valid) |-> !$past(in_valid && in_ready))

	// A length write starts the clearing pass, which blocks items.
	`ASSERT_CLK(a_len_clear,
		cfg_valid && cfg_ready && cfg_index == REG_DELAY_LENGTH |=> !in_ready)

	// Configuration writes are always taken.
	`ASSERT_NEVER(a_cfg_ready, !cfg_ready)

endmodule

bind modulated_delay_line_cubic_feedback_core mdlcf_chk u_chk (.*);

@@ tb/tb_modulated_delay_line_cubic_feedback_core.sv @@
// Testbench for the modulated delay line: directed and random sample items checked against a predictor.
module tb_modulated_delay_line_cubic_feedback_core;
	import mdlcf_pkg::*;

	typedef struct {
		logic                       act;
		logic signed [SAMPLE_W-1:0] x;
		logic [MOD_W-1:0]           m;
		logic signed [GAIN_W-1:0]   g;
	} sample_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = REG_DELAY_LENGTH;
	logic [LEN_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_PROCESS;
	logic signed [SAMPLE_W-1:0] audio_in = '0;
	logic [MOD_W-1:0] modulation = '0;
	logic signed [GAIN_W-1:0] feedback_gain = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_W-1:0] audio_out;

	modulated_delay_line_cubic_feedback_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .audio_in(audio_in),
		.modulation(modulation), .feedback_gain(feedback_gain),
		.out_valid(out_valid), .out_ready(out_ready), .audio_out(audio_out)
	);

	always #6 clk = ~clk;

	// Items waiting to be sent, and delayed samples still to come out.
	sample_item_t pending_items[$];
	logic signed [SAMPLE_W-1:0] expected_samples[$];
	sample_item_t item_on_port;
	bit item_taken = 0;
	int sender_idle_pct = 8;
	int recv_idle_pct = 73;
	int mismatches = 0;

	// Predictor state.
	int ring[STORE_DEPTH];
	int unsigned wr_ptr = 0;
	int unsigned glide_pos = 0;
	longint last_sample = 0;
	int unsigned len_reg = 0;
	bit digital_mode = MODE_ANALOG;

	function automatic longint clip24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	function void clear_ring();
		foreach (ring[k]) ring[k] = 0;
	endfunction

	function longint ring_at(int unsigned back, int unsigned span);
		return ring[(wr_ptr + span - back) % span];
	endfunction

	// Computes the delayed sample for one item and advances the predictor state.
	function logic signed [SAMPLE_W-1:0] next_delayed_sample(sample_item_t it);
		int unsigned len_eff, span, ip, fr;
		longint unsigned target, t, q, nr;
		longint y0, y1, y2, y3, f, r, a, b, c;
		len_eff = (len_reg > LEN_CAP) ? LEN_CAP : len_reg;
		span = len_eff + EXTRA_TAPS;
		if (it.act == ACT_CLEAR) begin
			clear_ring();
			return '0;
		end
		if (wr_ptr >= span) wr_ptr = 0;
		target = longint'(it.m) * len_eff;
		if (digital_mode == MODE_DIGITAL) begin
			glide_pos = target[31:0];
			ip = glide_pos >> 16;
			fr = glide_pos & 32'hFFFF;
			if (ip >= len_eff) begin
				ip = len_eff;
				fr = 0;
			end
		end else begin
			t = (target < 65536) ? 65536 : target;
			q = (longint'(glide_pos) << 16) / t;
			nr = longint'(glide_pos) + 65536;
			nr = (nr > q) ? nr - q : 0;
			if (nr > 64'hFFFF_FFFF) nr = 64'hFFFF_FFFF;
			glide_pos = nr[31:0];
			ip = glide_pos >> 16;
			fr = glide_pos & 32'hFFFF;
			if (ip > len_eff) begin
				ip = len_eff;
				fr = 0;
			end
		end
		ring[wr_ptr] = clip24(longint'(it.x) + ((last_sample * longint'(it.g) + 8192) >>> 14));
		f = fr;
		y1 = ring_at(ip, span);
		y2 = ring_at(ip + 1, span);
		if (ip == 0) begin
			r = y1 + ((f * (y2 - y1)) >>> 16);
		end else begin
			y0 = ring_at(ip - 1, span);
			y3 = ring_at(ip + 2, span);
			a = 3 * (y1 - y2) + y3 - y0;
			b = 2 * y0 - 5 * y1 + 4 * y2 - y3 + ((f * a) >>> 16);
			c = y2 - y0 + ((f * b) >>> 16);
			r = y1 + ((f * c) >>> 17);
		end
		last_sample = clip24(r);
		wr_ptr = (wr_ptr + 1 >= span) ? 0 : wr_ptr + 1;
		return last_sample[SAMPLE_W-1:0];
	endfunction

	// Driver: presents the next pending item at the falling edge.
	always @(negedge clk) begin
		if (in_valid && !item_taken) begin
			in_valid <= 1'b1;
		end else begin
			item_taken = 0;
			if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				item_on_port = pending_items.pop_front();
				action <= item_on_port.act;
				audio_in <= item_on_port.x;
				modulation <= item_on_port.m;
				feedback_gain <= item_on_port.g;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Monitor: records accepted items and checks delivered samples.
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_taken = 1;
			expected_samples.push_back(next_delayed_sample(item_on_port));
		end
		if (out_valid && out_ready) begin
			if (expected_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected sample %0d", audio_out);
			end else begin
				logic signed [SAMPLE_W-1:0] want;
				want = expected_samples.pop_front();
				if (audio_out !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("audio_out mismatch: expected %0d, got %0d", want, audio_out);
				end
			end
		end
	end

	// Waits until every item has been sent and every sample has come out.
	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_samples.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [LEN_W-1:0] value);
		@(negedge clk);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_DELAY_LENGTH) begin
			len_reg = value;
			clear_ring();
			wr_ptr = 0;
		end else begin
			digital_mode = value[0];
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic configure(int unsigned len, logic md);
		wait_drained();
		write_reg(REG_DELAY_LENGTH, len[LEN_W-1:0]);
		write_reg(REG_MODE, LEN_W'(md));
	endtask

	task automatic add_item(logic act, int x, int unsigned m, int g);
		sample_item_t it;
		it.act = act;
		it.x = x[SAMPLE_W-1:0];
		it.m = m[MOD_W-1:0];
		it.g = g[GAIN_W-1:0];
		pending_items.push_back(it);
	endtask

	// Random item: mostly in-range modulation, some beyond full, rare clears.
	task automatic add_random_item();
		int unsigned m;
		int g;
		case ($urandom_range(19))
			0: m = $urandom_range(131071, 65537);
			1: m = $urandom_range(200);
			default: m = $urandom_range(65536);
		endcase
		g = ($urandom_range(9) == 0) ? $urandom_range(65535) - 32768
			: $urandom_range(24000) - 12000;
		add_item(($urandom_range(63) == 0) ? ACT_CLEAR : ACT_PROCESS,
			$urandom_range(16777215) - 8388608, m, g);
	endtask

	// Random phases: delay length, mode and item count.
	int unsigned phase_len[6] = '{5, 37, 300, 1, 12, 4093};
	bit phase_mode[6] = '{MODE_ANALOG, MODE_DIGITAL, MODE_ANALOG, MODE_DIGITAL, MODE_ANALOG,
		MODE_DIGITAL};
	int phase_count[6] = '{200, 200, 150, 150, 170, 60};

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: digital short line, extremes of every field, a clear.
		configure(8, MODE_DIGITAL);
		add_item(ACT_PROCESS, 8388607, 0, 0);
		add_item(ACT_PROCESS, -8388608, 65536, 32767);
		add_item(ACT_PROCESS, 8388607, 131071, -32768);
		add_item(ACT_PROCESS, 123456, 32768 + 4321, 16384);
		add_item(ACT_PROCESS, -777777, 8191, -16384);
		add_item(ACT_PROCESS, 4000000, 20000, 32767);
		add_item(ACT_CLEAR, -1, 65536, -1);
		add_item(ACT_PROCESS, 1000, 40000, 0);
		add_item(ACT_PROCESS, -1, 60000, 8000);
		// Zero length in analog mode: delay is always zero.
		configure(0, MODE_ANALOG);
		add_item(ACT_PROCESS, 5000, 65536, 100);
		add_item(ACT_PROCESS, -5000, 131071, -100);
		add_item(ACT_PROCESS, 8388607, 0, 32767);
		// Longest line, analog glide then digital full delay.
		configure(4093, MODE_ANALOG);
		add_item(ACT_PROCESS, 3000000, 65536, 0);
		add_item(ACT_PROCESS, -3000000, 100, 5000);
		add_item(ACT_PROCESS, 77, 131071, 0);
		wait_drained();
		write_reg(REG_MODE, LEN_W'(MODE_DIGITAL));
		add_item(ACT_PROCESS, 42, 65536, 0);
		add_item(ACT_PROCESS, 43, 65535, 0);
		add_item(ACT_PROCESS, 44, 131071, 0);

		// Random phases with changing idle patterns.
		for (int ph = 0; ph < 6; ph++) begin
			configure(phase_len[ph], phase_mode[ph]);
			if (ph < 2) begin
				sender_idle_pct = 8;
				recv_idle_pct = 73;
			end else if (ph < 4) begin
				sender_idle_pct = 73;
				recv_idle_pct = 8;
			end else begin
				sender_idle_pct = 0;
				recv_idle_pct = 0;
			end
			for (int n = 0; n < phase_count[ph]; n++) begin
				// Hold off the sender until the line has drained once.
				if (ph == 1 && n == phase_count[ph] / 2) wait_drained();
				add_random_item();
			end
		end

		wait_drained();
		if (mismatches == 0 && expected_samples.size() == 0) begin
			$display("tb_modulated_delay_line_cubic_feedback_core passed");
		end else begin
			$display("tb_modulated_delay_line_cubic_feedback_core failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#(12 * 3000000);
		$display("tb_modulated_delay_line_cubic_feedback_core failed");
		$finish;
	end

endmodule

@@ modulated_delay_line_cubic_feedback_core.f @@
+incdir+src
src/mdlcf_pkg.sv
src/mdlcf_sermul.sv
src/mdlcf_serdiv.sv
src/modulated_delay_line_cubic_feedback_core.sv
src/mdlcf_chk.sv
tb/tb_modulated_delay_line_cubic_feedback_core.sv
